/* hw/rtl/crtc_pkg.sv */
// Package with the shared types and codes of the CRT controller command port.
`default_nettype none
package crtc_pkg;

	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_PARAM   = 2'd1;
	localparam logic [1:0] KIND_MODE    = 2'd2;

	localparam logic [2:0] OP_SET_SCREEN    = 3'd0;
	localparam logic [2:0] OP_START_DISPLAY = 3'd1;
	localparam logic [2:0] OP_LOAD_CURSOR   = 3'd4;

	localparam logic [1:0] PEND_NONE   = 2'd0;
	localparam logic [1:0] PEND_SCREEN = 2'd1;
	localparam logic [1:0] PEND_CURSOR = 2'd2;

	localparam logic [2:0] PARAM_INDEX_MAX = 3'd7;
	localparam logic [2:0] PARAM_INDEX_END = 3'd5;
	localparam logic [2:0] PARAM_LINE_MODE = 3'd1;
	localparam logic [6:0] LINES_24        = 7'd24;

	typedef struct packed {
		logic [1:0] pending_command;
		logic [2:0] param_index;
		logic       line_mode;
		logic       width_mode;
		logic       color_bit;
		logic [1:0] screen_code;
		logic       reverse_bit;
		logic       blank_bit;
		logic       cursor_enable;
		logic [6:0] cursor_col;
		logic [5:0] cursor_row;
	} state_t;

	typedef struct packed {
		logic mode_changed;
		logic color_changed;
		logic attr_invalidate;
		logic cursor_moved;
	} pulse_t;

	localparam state_t STATE_RESET = '{
		pending_command: PEND_NONE,
		param_index:     3'd0,
		line_mode:       1'b1,
		width_mode:      1'b0,
		color_bit:       1'b1,
		screen_code:     2'd1,
		reverse_bit:     1'b0,
		blank_bit:       1'b0,
		cursor_enable:   1'b0,
		cursor_col:      7'd0,
		cursor_row:      6'd0
	};

endpackage
`default_nettype wire

/* hw/rtl/crtc_decode.sv */
// Port write decoder that computes the next controller state and the side-effect pulses.
`default_nettype none
module crtc_decode (
	input  wire crtc_pkg::state_t state,
	input  wire logic [1:0]       kind,
	input  wire logic [7:0]       value,
	output crtc_pkg::state_t      state_next,
	output crtc_pkg::pulse_t      pulse
);

	logic       lm;
	logic [2:0] cnt;

	always_comb begin
		state_next = state;
		pulse      = '0;
		cnt        = state.param_index;
		lm         = (value[6:0] == crtc_pkg::LINES_24);
		case (kind)
			crtc_pkg::KIND_COMMAND: begin
				case (value[7:5])
					crtc_pkg::OP_SET_SCREEN: begin
						state_next.pending_command = crtc_pkg::PEND_SCREEN;
						state_next.param_index     = 3'd0;
						state_next.blank_bit       = 1'b1;
					end
					crtc_pkg::OP_START_DISPLAY: begin
						state_next.reverse_bit = value[0];
						state_next.blank_bit   = 1'b0;
						pulse.attr_invalidate  = 1'b1;
					end
					crtc_pkg::OP_LOAD_CURSOR: begin
						state_next.pending_command = crtc_pkg::PEND_CURSOR;
						state_next.param_index     = 3'd0;
						state_next.cursor_enable   = value[0];
					end
					default: begin
						state_next.pending_command = crtc_pkg::PEND_NONE;
						state_next.param_index     = 3'd0;
					end
				endcase
			end
			crtc_pkg::KIND_PARAM: begin
				if (cnt != crtc_pkg::PARAM_INDEX_MAX) begin
					state_next.param_index = cnt + 3'd1;
				end
				case (state.pending_command)
					crtc_pkg::PEND_SCREEN: begin
						if (cnt >= crtc_pkg::PARAM_INDEX_END) begin
							state_next.pending_command = crtc_pkg::PEND_NONE;
						end else if (cnt == crtc_pkg::PARAM_LINE_MODE && lm != state.line_mode) begin
							state_next.line_mode   = lm;
							state_next.screen_code = {state.width_mode, lm};
							pulse.mode_changed     = 1'b1;
							pulse.attr_invalidate  = 1'b1;
						end
					end
					crtc_pkg::PEND_CURSOR: begin
						if (cnt == 3'd0) begin
							state_next.cursor_col = value[6:0];
						end else begin
							state_next.cursor_row      = value[5:0];
							state_next.pending_command = crtc_pkg::PEND_NONE;
						end
						pulse.cursor_moved = 1'b1;
					end
					default: begin
					end
				endcase
			end
			crtc_pkg::KIND_MODE: begin
				if (value[0] != state.width_mode) begin
					state_next.width_mode  = value[0];
					state_next.screen_code = {value[0], state.line_mode};
					pulse.mode_changed     = 1'b1;
				end
				if (value[1] != state.color_bit) begin
					state_next.color_bit = value[1];
					pulse.color_changed  = 1'b1;
				end
				pulse.attr_invalidate = pulse.mode_changed | pulse.color_changed;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/crt_controller_command_port.sv */
// Top level of the CRT controller command port: input register, state and result register.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   in       | in_valid, in_stall | kind, value
//   out      | out_valid, out_stall | screen_mode .. cursor_moved (one per write)
//
// Each write passes through the input register and then the result register. A new
// write can be accepted every cycle unless a stalled result holds the input register.
// The controller state updates as a write moves into the result register, so the
// following write already decodes against it. Reset puts the controller state and
// valid flags at defined values; in_stall rises only while a result is stalled.
`default_nettype none
module crt_controller_command_port (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  logic       in_valid,
	output logic             in_stall,
	input  wire  logic [1:0] kind,
	input  wire  logic [7:0] value,
	output logic             out_valid,
	input  wire  logic       out_stall,
	output logic [1:0]       screen_mode,
	output logic             color_mode,
	output logic             reverse_video,
	output logic             text_blanked,
	output logic             cursor_on,
	output logic [6:0]       cursor_x,
	output logic [5:0]       cursor_y,
	output logic             mode_changed,
	output logic             color_changed,
	output logic             attr_invalidate,
	output logic             cursor_moved
);

	logic             valid_s1;
	logic [1:0]       kind_s1;
	logic [7:0]       value_s1;
	logic             valid_s2;
	crtc_pkg::state_t result_s2;
	crtc_pkg::pulse_t pulse_s2;
	crtc_pkg::state_t state_q;
	crtc_pkg::state_t state_next;
	crtc_pkg::pulse_t pulse_next;
	logic             advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	crtc_decode u_decode (
		.state      (state_q),
		.kind       (kind_s1),
		.value      (value_s1),
		.state_next (state_next),
		.pulse      (pulse_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= crtc_pkg::STATE_RESET;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1  <= kind;
			value_s1 <= value;
		end
		if (advance) begin
			result_s2 <= state_next;
			pulse_s2  <= pulse_next;
		end
	end

	assign out_valid       = valid_s2;
	assign screen_mode     = result_s2.screen_code;
	assign color_mode      = result_s2.color_bit;
	assign reverse_video   = result_s2.reverse_bit;
	assign text_blanked    = result_s2.blank_bit;
	assign cursor_on       = result_s2.cursor_enable;
	assign cursor_x        = result_s2.cursor_col;
	assign cursor_y        = result_s2.cursor_row;
	assign mode_changed    = pulse_s2.mode_changed;
	assign color_changed   = pulse_s2.color_changed;
	assign attr_invalidate = pulse_s2.attr_invalidate;
	assign cursor_moved    = pulse_s2.cursor_moved;

endmodule
`default_nettype wire

/* hw/rtl/crtc_checker.sv */
// Port checker for the CRT controller command port and its bind to the top level.
`default_nettype none
module crtc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic text_blanked,
	input wire logic mode_changed,
	input wire logic color_changed,
	input wire logic attr_invalidate
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("A stalled result transfer was dropped.");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("The input stalled while the result register was empty.");

	a_color_invalidates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && color_changed |-> attr_invalidate)
		else $error("A color change did not invalidate the attribute cache.");

	a_start_unblanks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && attr_invalidate && !mode_changed && !color_changed |-> !text_blanked)
		else $error("Start-display left the text blanked.");

endmodule

bind crt_controller_command_port crtc_checker u_crtc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.text_blanked    (text_blanked),
	.mode_changed    (mode_changed),
	.color_changed   (color_changed),
	.attr_invalidate (attr_invalidate)
);
`default_nettype wire
